>>> rtl/laplacian_highpass_sharpen_top_defines.svh
// assertion macros for the laplacian sharpen block
// expects clock and reset in the scope of the module that uses them
`ifndef LAPLACIAN_HIGHPASS_SHARPEN_TOP_DEFINES_SVH
`define LAPLACIAN_HIGHPASS_SHARPEN_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define LHS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define LHS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lhs_pkg.sv
// shared types and constants of the laplacian sharpen block
// used by the stream interfaces and the top level
package lhs_pkg;

   localparam int CFG_SIZE_W  = 11;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int PIXEL_W     = 8;
   localparam int SUM_W       = 13;
   localparam int OUT_DEPTH   = 8;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

   typedef logic [PIXEL_W-1:0]    pixel_type;
   typedef logic                  op_type;
   typedef logic [CFG_SIZE_W-1:0] size_type;
   typedef logic [1:0]            kernel_type;
   typedef logic [1:0]            reg_index_type;

   localparam op_type OP_PIXEL = 1'b0;
   localparam op_type OP_DRAIN = 1'b1;

   localparam reg_index_type REG_WIDTH   = 2'd0;
   localparam reg_index_type REG_HEIGHT  = 2'd1;
   localparam reg_index_type REG_KERNEL  = 2'd2;
   localparam reg_index_type REG_SHARPEN = 2'd3;

   localparam kernel_type KERNEL_BASIC     = 2'd0;
   localparam kernel_type KERNEL_FULL      = 2'd1;
   localparam kernel_type KERNEL_BASIC_INV = 2'd2;
   localparam kernel_type KERNEL_FULL_INV  = 2'd3;

   localparam size_type RESET_WIDTH  = 11'd640;
   localparam size_type RESET_HEIGHT = 11'd480;

   localparam pixel_type PIXEL_MAX = 8'd255;

   typedef struct packed {
      pixel_type value;
      logic      frame_last;
   } result_type;

endpackage

>>> rtl/lhs_req_if.sv
// input pixel stream channel of the laplacian sharpen block
// depends on lhs_pkg
interface lhs_req_if;
   import lhs_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   pixel_type pixel;

   modport source (output valid, output operation, output pixel, input ready);
   modport sink (input valid, input operation, input pixel, output ready);
endinterface

>>> rtl/lhs_rsp_if.sv
// result pixel stream channel of the laplacian sharpen block
// depends on lhs_pkg
interface lhs_rsp_if;
   import lhs_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type value;
   logic      frame_last;

   modport source (output valid, output value, output frame_last, input ready);
   modport sink (input valid, input value, input frame_last, output ready);
endinterface

>>> rtl/laplacian_highpass_sharpen_top.sv
// channel  dir  handshake            payload
// req      in   valid / ready        operation, pixel
// rsp      out  valid / ready        value, frame_last
// csr      in   apb, pready tied 1   width, height, kernel, sharpen at byte 4*i
//
// one word per cycle while req.ready high; results pass stages 1-3 and the queue
// rate set by read-modify-write of both line memories, 1 read + 1 write port each
// req.ready drops only while 8 results are accepted but not yet taken on rsp
// synchronous reset loads 640x480, basic kernel, no sharpening; no clearing pass,
// a fill count makes never-written line entries read as zero
`include "laplacian_highpass_sharpen_top_defines.svh"

module laplacian_highpass_sharpen_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   lhs_req_if.sink                             req,
   lhs_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lhs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [lhs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [lhs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import lhs_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int FW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT);

   typedef struct packed {
      logic          valid;
      logic          wr;
      logic          emit;
      logic          drain;
      logic          inner;
      logic          last;
      logic          mid_sel;
      logic [AW-1:0] addr;
      pixel_type     pixel;
   } stage1_type;

   typedef struct packed {
      logic      valid;
      logic      inner;
      logic      last;
      pixel_type centre;
   } stage2_type;

   typedef struct packed {
      logic              valid;
      logic              inner;
      logic              last;
      pixel_type         centre;
      logic [SUM_W-1:0]  sum;
   } stage3_type;

   // configuration registers
   size_type   width_ff;
   size_type   height_ff;
   kernel_type kernel_ff;
   logic       sharpen_ff;
   logic       csr_wr_c;
   logic       size_wr_c;

   assign pready   = 1'b1;
   assign csr_wr_c = psel && penable && pwrite;
   assign size_wr_c = csr_wr_c &&
                      (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RESET_WIDTH;
         height_ff  <= RESET_HEIGHT;
         kernel_ff  <= KERNEL_BASIC;
         sharpen_ff <= 1'b0;
      end else if (csr_wr_c) begin
         unique case (paddr[3:2])
            REG_WIDTH:   width_ff   <= pwdata[CFG_SIZE_W-1:0];
            REG_HEIGHT:  height_ff  <= pwdata[CFG_SIZE_W-1:0];
            REG_KERNEL:  kernel_ff  <= pwdata[1:0];
            REG_SHARPEN: sharpen_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_WIDTH:   prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT:  prdata = CSR_DATA_W'(height_ff);
         REG_KERNEL:  prdata = CSR_DATA_W'(kernel_ff);
         REG_SHARPEN: prdata = CSR_DATA_W'(sharpen_ff);
         default:     prdata = '0;
      endcase
   end

   // effective last column and last row, size clamped to 1..max
   logic [AW-1:0] w_last_c;
   logic [HW-1:0] h_last_c;

   always_comb begin
      if (width_ff == '0) begin
         w_last_c = '0;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_last_c = AW'(MAX_WIDTH - 1);
      end else begin
         w_last_c = AW'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         h_last_c = '0;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_last_c = HW'(MAX_HEIGHT - 1);
      end else begin
         h_last_c = HW'(height_ff - 1'b1);
      end
   end

   // frame position counters
   logic [AW-1:0]        rx_col_ff, rx_col_in;
   logic [HW-1:0]        rx_row_ff, rx_row_in;
   logic                 rx_full_ff, rx_full_in;
   logic [AW-1:0]        em_col_ff, em_col_in;
   logic [HW-1:0]        em_row_ff, em_row_in;
   logic [OUT_CNT_W-1:0] pend_ff, pend_in;

   logic acc_c, is_pix_c, pix_take_c, emit_c, em_last_c, inner_c, pop_c;
   logic [AW-1:0] rd_addr_c;

   assign req.ready  = pend_ff < OUT_CNT_W'(OUT_DEPTH);
   assign acc_c      = req.valid && req.ready;
   assign is_pix_c   = req.operation == OP_PIXEL;
   assign pix_take_c = is_pix_c && !rx_full_ff;
   assign emit_c     = is_pix_c ? (pix_take_c && ((rx_row_ff > HW'(1)) ||
                                   (rx_row_ff == HW'(1) && rx_col_ff != '0)))
                                : rx_full_ff;
   assign em_last_c  = (em_row_ff == h_last_c) && (em_col_ff == w_last_c);
   assign inner_c    = is_pix_c && (em_row_ff != '0) && (em_row_ff < h_last_c) &&
                       (em_col_ff != '0) && (em_col_ff < w_last_c);
   assign rd_addr_c  = is_pix_c ? rx_col_ff : em_col_ff;
   assign pop_c      = rsp.valid && rsp.ready;

   always_comb begin
      rx_col_in  = rx_col_ff;
      rx_row_in  = rx_row_ff;
      rx_full_in = rx_full_ff;
      em_col_in  = em_col_ff;
      em_row_in  = em_row_ff;
      pend_in    = OUT_CNT_W'(pend_ff + OUT_CNT_W'(acc_c && emit_c) - OUT_CNT_W'(pop_c));
      if (acc_c && pix_take_c) begin
         if (rx_col_ff == w_last_c) begin
            rx_col_in = '0;
            if (rx_row_ff == h_last_c) begin
               rx_full_in = 1'b1;
            end else begin
               rx_row_in = HW'(rx_row_ff + 1'b1);
            end
         end else begin
            rx_col_in = AW'(rx_col_ff + 1'b1);
         end
      end
      if (acc_c && emit_c) begin
         if (em_last_c) begin
            // frame done, next pixel opens a new frame
            rx_col_in  = '0;
            rx_row_in  = '0;
            rx_full_in = 1'b0;
            em_col_in  = '0;
            em_row_in  = '0;
         end else if (em_col_ff == w_last_c) begin
            em_col_in = '0;
            em_row_in = HW'(em_row_ff + 1'b1);
         end else begin
            em_col_in = AW'(em_col_ff + 1'b1);
         end
      end
      if (size_wr_c) begin
         rx_col_in  = '0;
         rx_row_in  = '0;
         rx_full_in = 1'b0;
         em_col_in  = '0;
         em_row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_col_ff  <= '0;
         rx_row_ff  <= '0;
         rx_full_ff <= 1'b0;
         em_col_ff  <= '0;
         em_row_ff  <= '0;
         pend_ff    <= '0;
      end else begin
         rx_col_ff  <= rx_col_in;
         rx_row_ff  <= rx_row_in;
         rx_full_ff <= rx_full_in;
         em_col_ff  <= em_col_in;
         em_row_ff  <= em_row_in;
         pend_ff    <= pend_in;
      end
   end

   // stage 1: line memory read data arrives, write back, window shift
   stage1_type s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= acc_c;
      end
      s1_ff.wr      <= acc_c && pix_take_c;
      s1_ff.emit    <= emit_c;
      s1_ff.drain   <= !is_pix_c;
      s1_ff.inner   <= inner_c;
      s1_ff.last    <= em_last_c;
      s1_ff.mid_sel <= em_row_ff == h_last_c;
      s1_ff.addr    <= rd_addr_c;
      s1_ff.pixel   <= req.pixel;
   end

   pixel_type     upper_mem  [MAX_WIDTH];
   pixel_type     middle_mem [MAX_WIDTH];
   pixel_type     up_q_ff, mid_q_ff;
   pixel_type     fwd_up_ff, fwd_mid_ff;
   logic          fwd_ff;
   logic          rd_ok_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic          mem_we_c;
   pixel_type     up_eff_c, mid_eff_c;

   assign mem_we_c  = s1_ff.valid && s1_ff.wr;
   // entries at or above the fill count were never written and read as zero
   assign up_eff_c  = fwd_ff ? fwd_up_ff  : (rd_ok_ff ? up_q_ff  : '0);
   assign mid_eff_c = fwd_ff ? fwd_mid_ff : (rd_ok_ff ? mid_q_ff : '0);

   always_ff @(posedge clock) begin
      if (mem_we_c) begin
         upper_mem[s1_ff.addr]  <= mid_eff_c;
         middle_mem[s1_ff.addr] <= s1_ff.pixel;
      end
      up_q_ff  <= upper_mem[rd_addr_c];
      mid_q_ff <= middle_mem[rd_addr_c];
   end

   // same-entry read while stage 1 writes it: take the write data
   always_ff @(posedge clock) begin
      fwd_ff     <= mem_we_c && (s1_ff.addr == rd_addr_c);
      fwd_up_ff  <= mid_eff_c;
      fwd_mid_ff <= s1_ff.pixel;
      rd_ok_ff   <= FW'(rd_addr_c) < fill_ff;
   end

   always_comb begin
      fill_in = fill_ff;
      if (mem_we_c && (FW'(s1_ff.addr) >= fill_ff)) begin
         fill_in = FW'(FW'(s1_ff.addr) + FW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // 3x3 window, row 0 oldest line, column 2 newest
   pixel_type win_ff [9];

   always_ff @(posedge clock) begin
      if (mem_we_c) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= up_eff_c;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= mid_eff_c;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= s1_ff.pixel;
      end
   end

   // stage 2: kernel sum over the window
   stage2_type s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s1_ff.valid && s1_ff.emit;
      end
      s2_ff.inner <= s1_ff.inner;
      s2_ff.last  <= s1_ff.last;
      // window centre after the shift is the middle-right pixel now
      if (s1_ff.drain) begin
         s2_ff.centre <= s1_ff.mid_sel ? mid_eff_c : up_eff_c;
      end else begin
         s2_ff.centre <= win_ff[5];
      end
   end

   logic [PIXEL_W+1:0] cross_c, corner_c;
   logic [SUM_W-1:0]   basic_c, full_c, sum_c;
   logic               full_sel_c, inv_sel_c;

   assign full_sel_c = (kernel_ff == KERNEL_FULL) || (kernel_ff == KERNEL_FULL_INV);
   assign inv_sel_c  = (kernel_ff == KERNEL_BASIC_INV) || (kernel_ff == KERNEL_FULL_INV);

   always_comb begin
      cross_c  = (PIXEL_W+2)'(win_ff[1]) + (PIXEL_W+2)'(win_ff[3]) +
                 (PIXEL_W+2)'(win_ff[5]) + (PIXEL_W+2)'(win_ff[7]);
      corner_c = (PIXEL_W+2)'(win_ff[0]) + (PIXEL_W+2)'(win_ff[2]) +
                 (PIXEL_W+2)'(win_ff[6]) + (PIXEL_W+2)'(win_ff[8]);
      basic_c  = SUM_W'(cross_c) - SUM_W'({win_ff[4], 2'b00});
      full_c   = SUM_W'(cross_c) + SUM_W'(corner_c) - SUM_W'({win_ff[4], 3'b000});
      sum_c    = full_sel_c ? full_c : basic_c;
      if (inv_sel_c) begin
         sum_c = SUM_W'(-sum_c);
      end
   end

   // stage 3: clamp, optional sharpening, push to output queue
   stage3_type s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else begin
         s3_ff.valid <= s2_ff.valid;
      end
      s3_ff.inner  <= s2_ff.inner;
      s3_ff.last   <= s2_ff.last;
      s3_ff.centre <= s2_ff.centre;
      s3_ff.sum    <= sum_c;
   end

   pixel_type          filt_c, res_c;
   logic signed [9:0]  sharp_c;

   always_comb begin
      if (!s3_ff.inner || $signed(s3_ff.sum) < 0) begin
         filt_c = '0;
      end else if ($signed(s3_ff.sum) > $signed(SUM_W'(PIXEL_MAX))) begin
         filt_c = PIXEL_MAX;
      end else begin
         filt_c = s3_ff.sum[PIXEL_W-1:0];
      end
      if (inv_sel_c) begin
         sharp_c = $signed({2'b00, s3_ff.centre}) + $signed({2'b00, filt_c});
      end else begin
         sharp_c = $signed({2'b00, s3_ff.centre}) - $signed({2'b00, filt_c});
      end
      if (!sharpen_ff) begin
         res_c = filt_c;
      end else if (sharp_c < 0) begin
         res_c = '0;
      end else if (sharp_c > $signed(10'(PIXEL_MAX))) begin
         res_c = PIXEL_MAX;
      end else begin
         res_c = sharp_c[PIXEL_W-1:0];
      end
   end

   // output queue, sized so the pipeline never stalls
   result_type           out_mem [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   assign out_cnt_in = OUT_CNT_W'(out_cnt_ff + OUT_CNT_W'(s3_ff.valid) - OUT_CNT_W'(pop_c));

   always_ff @(posedge clock) begin
      if (s3_ff.valid) begin
         out_mem[wr_ptr_ff] <= '{value: res_c, frame_last: s3_ff.last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (s3_ff.valid) begin
            wr_ptr_ff <= OUT_PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop_c) begin
            rd_ptr_ff <= OUT_PTR_W'(rd_ptr_ff + 1'b1);
         end
         out_cnt_ff <= out_cnt_in;
      end
   end

   assign rsp.valid      = out_cnt_ff != '0;
   assign rsp.value      = out_mem[rd_ptr_ff].value;
   assign rsp.frame_last = out_mem[rd_ptr_ff].frame_last;

   `LHS_ASSERT_SAME(a_pend_bound, 1'b1, pend_ff <= OUT_CNT_W'(OUT_DEPTH), "pending word count above queue depth")
   `LHS_ASSERT_SAME(a_queue_le_pend, 1'b1, out_cnt_ff <= pend_ff, "queue holds more words than are pending")
   `LHS_ASSERT_NEXT(a_full_no_write, acc_c && is_pix_c && rx_full_ff, !s1_ff.wr, "line memory written after frame was full")
   `LHS_ASSERT_NEXT(a_last_clears, acc_c && emit_c && em_last_c, !rx_full_ff && (em_col_ff == '0) && (em_row_ff == '0), "counters not cleared after last word of frame")
   `LHS_ASSERT_NEXT(a_emit_enters, acc_c && emit_c, s1_ff.valid && s1_ff.emit, "emitting word lost at stage 1")

endmodule
